[rtl/vlmc_pkg.sv]
// Shared types, codes and reset values for the vehicle lamp mode controller.
`default_nettype none

package vlmc_pkg;

  // Event kinds carried in the operation field
  typedef enum logic [1:0] {
    OP_SPEED = 2'd0,
    OP_EMERG = 2'd1,
    OP_BATT  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SPEED_THRESHOLD = 2'd0,
    CFG_SPEED_TIMEOUT   = 2'd1,
    CFG_STOP_TICKS      = 2'd2,
    CFG_FULL_VOLTAGE    = 2'd3
  } cfg_idx_t;

  // Direction of travel as last shown
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  // Mode codes on the result channel
  typedef enum logic [2:0] {
    MODE_FULL     = 3'd0,
    MODE_CHARGING = 3'd1,
    MODE_EMERG    = 3'd2,
    MODE_REVERSE  = 3'd3,
    MODE_FORWARD  = 3'd4,
    MODE_STOPPED  = 3'd5
  } mode_t;

  localparam logic [7:0] PAT_FULL     = 8'h11;
  localparam logic [7:0] PAT_CHARGING = 8'h33;
  localparam logic [7:0] PAT_EMERG    = 8'h66;
  localparam logic [7:0] PAT_REVERSE  = 8'h52;
  localparam logic [7:0] PAT_FORWARD  = 8'h25;
  localparam logic [7:0] PAT_STOPPED  = 8'h77;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  localparam logic [14:0] RST_SPEED_THRESHOLD = 15'd10;
  localparam logic [7:0]  RST_SPEED_TIMEOUT   = 8'd10;
  localparam logic [7:0]  RST_STOP_TICKS      = 8'd10;
  localparam logic [15:0] RST_FULL_VOLTAGE    = 16'd29500;

  // Flag vector layout: bit0 emergency clear, bit1 charging, bit2 full
  localparam logic [2:0] RST_PRIOR_FLAGS = 3'b001;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] speed_mm_s;
    logic               stop_input_a;
    logic               stop_input_b;
    logic               is_charging;
    logic [15:0]        voltage_mv;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lamp_pattern;
    logic [2:0] mode_code;
  } out_item_t;

  typedef struct packed {
    logic [14:0] speed_threshold;
    logic [7:0]  speed_timeout_ticks;
    logic [7:0]  stop_ticks;
    logic [15:0] full_voltage_mv;
  } cfg_t;

  typedef struct packed {
    logic [15:0] held_speed;
    logic [7:0]  ticks_since_speed;
    dir_t        shown_direction;
    logic        emergency_clear;
    logic        charging_now;
    logic        full_now;
    logic [7:0]  stopped_count;
    logic        stop_shown;
    logic [2:0]  prior_flags;
  } state_t;

endpackage

`default_nettype wire

[rtl/vlmc_step.sv]
// Next-state and result logic for one event of the lamp mode controller.
`default_nettype none

module vlmc_step
  import vlmc_pkg::*;
(
  input  state_t    st,
  input  cfg_t      cfg,
  input  in_item_t  item,
  output state_t    st_nxt,
  output logic      emit,
  output out_item_t result
);

  logic               clr;
  logic               full;
  logic [7:0]         ticks;
  logic signed [16:0] sp;
  logic signed [16:0] thr;
  logic [15:0]        speed;
  dir_t               dir;
  logic [7:0]         cnt;
  logic               shown;
  logic [2:0]         flags;

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    result = '{lamp_pattern: PAT_STOPPED, mode_code: MODE_STOPPED};
    clr    = item.stop_input_a & item.stop_input_b;
    full   = item.voltage_mv >= cfg.full_voltage_mv;
    ticks  = (st.ticks_since_speed == COUNT_MAX) ? COUNT_MAX
                                                 : st.ticks_since_speed + 8'd1;
    speed  = (ticks > cfg.speed_timeout_ticks) ? 16'd0 : st.held_speed;
    sp     = {speed[15], speed};
    thr    = {2'b00, cfg.speed_threshold};
    dir    = DIR_STOP;
    cnt    = st.stopped_count;
    shown  = st.stop_shown;
    flags  = {st.full_now, st.charging_now, st.emergency_clear};

    case (op_t'(item.operation))
      OP_SPEED: begin
        st_nxt.held_speed        = item.speed_mm_s;
        st_nxt.ticks_since_speed = 8'd0;
      end
      OP_EMERG: begin
        if (clr != st.emergency_clear) begin
          st_nxt.emergency_clear = clr;
          if (clr) begin
            st_nxt.stop_shown = 1'b0;
          end
        end
      end
      OP_BATT: begin
        if (item.is_charging != st.charging_now || full != st.full_now) begin
          st_nxt.charging_now = item.is_charging;
          st_nxt.full_now     = full & item.is_charging;
        end
      end
      OP_TICK: begin
        st_nxt.ticks_since_speed = ticks;
        st_nxt.held_speed        = speed;
        // classify motion against the dead band
        if (sp < -thr) begin
          dir   = DIR_REV;
          cnt   = 8'd0;
          shown = 1'b0;
        end else if (sp > thr) begin
          dir   = DIR_FWD;
          cnt   = 8'd0;
          shown = 1'b0;
        end else if (cnt != COUNT_MAX) begin
          cnt = cnt + 8'd1;
        end
        // charging has just ended: force stop mode
        if (!st.charging_now && !st.full_now && st.prior_flags[1]) begin
          dir   = DIR_STOP;
          cnt   = cfg.stop_ticks;
          shown = 1'b0;
        end
        if (!(dir == st.shown_direction && flags == st.prior_flags &&
              (shown || cnt < cfg.stop_ticks))) begin
          emit = 1'b1;
          if (st.full_now) begin
            result = '{lamp_pattern: PAT_FULL, mode_code: MODE_FULL};
          end else if (st.charging_now) begin
            result = '{lamp_pattern: PAT_CHARGING, mode_code: MODE_CHARGING};
          end else if (!st.emergency_clear) begin
            result = '{lamp_pattern: PAT_EMERG, mode_code: MODE_EMERG};
          end else if (dir == DIR_REV) begin
            result = '{lamp_pattern: PAT_REVERSE, mode_code: MODE_REVERSE};
          end else if (dir == DIR_FWD) begin
            result = '{lamp_pattern: PAT_FORWARD, mode_code: MODE_FORWARD};
          end else if (cnt >= cfg.stop_ticks && !shown) begin
            shown = 1'b1;
          end else begin
            emit = 1'b0;
          end
          st_nxt.shown_direction = dir;
          st_nxt.prior_flags     = flags;
        end
        st_nxt.stopped_count = cnt;
        st_nxt.stop_shown    = shown;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/vehicle_lamp_mode_controller_unit.sv]
// Top level of the vehicle lamp mode controller: registers, handshakes and result stage.
`default_nettype none

// The controller takes one event item per clock while in_ready is high: a
// speed sample, the two emergency line levels, a battery report or a 100 ms
// tick. Every item is absorbed in the cycle it is accepted; the whole state
// update and the lamp choice are one level of short logic between the state
// and result registers; while results drain the sustained rate is one item per cycle and
// a result appears on out_valid the cycle after the tick that caused it. Only ticks
// produce results, and only when the direction, the emergency/charging/full
// flags or the stop timer call for a new pattern. The result register acts
// as the stage between the two sides: in_ready stays high while it is empty
// or being drained, and drops only while a result waits with out_ready low.
// Configuration writes are taken at any time (cfg_ready is tied high) and
// should be made while the block is idle. There is no clearing pass after
// reset: the block is ready on the first cycle out of reset.
module vehicle_lamp_mode_controller_unit
  import vlmc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  // event items
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  // lamp results
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  // register writes
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t      cfg_r;
  state_t    st_r;
  state_t    st_nxt;
  logic      emit;
  out_item_t result;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      in_acc;

  // Accept a new item whenever the result stage is free or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  vlmc_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (in_data),
    .st_nxt (st_nxt),
    .emit   (emit),
    .result (result)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_threshold     <= RST_SPEED_THRESHOLD;
      cfg_r.speed_timeout_ticks <= RST_SPEED_TIMEOUT;
      cfg_r.stop_ticks          <= RST_STOP_TICKS;
      cfg_r.full_voltage_mv     <= RST_FULL_VOLTAGE;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SPEED_THRESHOLD: cfg_r.speed_threshold     <= cfg_data[14:0];
        CFG_SPEED_TIMEOUT:   cfg_r.speed_timeout_ticks <= cfg_data[7:0];
        CFG_STOP_TICKS:      cfg_r.stop_ticks          <= cfg_data[7:0];
        CFG_FULL_VOLTAGE:    cfg_r.full_voltage_mv     <= cfg_data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Controller state: advance on every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.held_speed        <= 16'd0;
      st_r.ticks_since_speed <= 8'd0;
      st_r.shown_direction   <= DIR_STOP;
      st_r.emergency_clear   <= 1'b1;
      st_r.charging_now      <= 1'b0;
      st_r.full_now          <= 1'b0;
      st_r.stopped_count     <= 8'd0;
      st_r.stop_shown        <= 1'b0;
      st_r.prior_flags       <= RST_PRIOR_FLAGS;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // Result stage: load on an emitting item, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_data_r <= result;
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the vehicle lamp mode controller top level.
`timescale 1ns / 1ps

module tb;
  import vlmc_pkg::*;

  // Directed stimulus row: event kind, its argument (speed or voltage), the
  // emergency lines and charging flag, and a typed-in lamp where one is obvious.
  typedef struct packed {
    op_t         op;
    logic [15:0] arg;
    logic        line_a;
    logic        line_b;
    logic        charging;
    logic        typed;
    logic        has_lamp;
    out_item_t   lamp;
  } plan_row_t;

  localparam int        PLAN_LEN = 24;
  localparam out_item_t NO_LAMP  = '0;

  // Rows flagged as typed carry their own expectation; the rest go through the
  // predictor. Reset thresholds apply throughout: 10 mm/s, 10 ticks, 29500 mV.
  plan_row_t plan [PLAN_LEN] = '{
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, NO_LAMP},
    '{OP_SPEED, 16'h7FFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, '{PAT_FORWARD, MODE_FORWARD}},
    '{OP_SPEED, 16'h8000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, '{PAT_REVERSE, MODE_REVERSE}},
    '{OP_SPEED, 16'h000A, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_SPEED, 16'hFFF5, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_EMERG, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, '{PAT_EMERG, MODE_EMERG}},
    '{OP_EMERG, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_EMERG, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_EMERG, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_BATT,  16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, '{PAT_FULL, MODE_FULL}},
    '{OP_BATT,  16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, '{PAT_CHARGING, MODE_CHARGING}},
    '{OP_BATT,  16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_SPEED, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP},
    '{OP_TICK,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_LAMP}
  };

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_SPEED_THRESHOLD;
  logic [15:0] cfg_data  = '0;

  // Receiver wish and the long hold-off combine into out_ready
  logic rx_want  = 1'b0;
  logic hold_off = 1'b0;
  bit   hold_req = 1'b0;
  assign out_ready = rx_want & ~hold_off;

  // Set for stretches where neither side idles
  bit calm = 1'b0;

  // Typed-in expectation for the item currently offered
  bit        typed_on  = 1'b0;
  bit        typed_has = 1'b0;
  out_item_t typed_lamp = '0;

  int unsigned fail_count = 0;

  // Predictor copy of the registers and the controller state
  cfg_t   lamp_cfg = '{RST_SPEED_THRESHOLD, RST_SPEED_TIMEOUT, RST_STOP_TICKS,
                       RST_FULL_VOLTAGE};
  state_t lamp_st  = '{held_speed: '0, ticks_since_speed: '0, shown_direction: DIR_STOP,
                       emergency_clear: 1'b1, charging_now: 1'b0, full_now: 1'b0,
                       stopped_count: '0, stop_shown: 1'b0, prior_flags: RST_PRIOR_FLAGS};

  out_item_t pending_lamps [$];

  vehicle_lamp_mode_controller_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance the predictor by one event; return whether a lamp pattern results.
  function automatic bit next_lamp(input in_item_t ev, output out_item_t lamp);
    int         sp;
    int         thr;
    dir_t       dir;
    logic [2:0] flags;
    logic       clear;
    logic       full;
    bit         emit;
    lamp = '0;
    emit = 1'b0;
    case (op_t'(ev.operation))
      OP_SPEED: begin
        lamp_st.held_speed        = ev.speed_mm_s;
        lamp_st.ticks_since_speed = '0;
      end
      OP_EMERG: begin
        clear = ev.stop_input_a & ev.stop_input_b;
        if (clear != lamp_st.emergency_clear) begin
          lamp_st.emergency_clear = clear;
          // release of the emergency stop re-arms the stop pattern
          if (clear) lamp_st.stop_shown = 1'b0;
        end
      end
      OP_BATT: begin
        full = ev.voltage_mv >= lamp_cfg.full_voltage_mv;
        if (ev.is_charging != lamp_st.charging_now || full != lamp_st.full_now) begin
          lamp_st.charging_now = ev.is_charging;
          lamp_st.full_now     = full & ev.is_charging;
        end
      end
      default: begin
        // age the held speed, saturating, and drop it after the timeout
        if (lamp_st.ticks_since_speed != COUNT_MAX)
          lamp_st.ticks_since_speed = lamp_st.ticks_since_speed + 8'd1;
        if (lamp_st.ticks_since_speed > lamp_cfg.speed_timeout_ticks)
          lamp_st.held_speed = '0;
        sp  = $signed(lamp_st.held_speed);
        thr = lamp_cfg.speed_threshold;
        dir = DIR_STOP;
        if (sp < -thr) begin
          dir = DIR_REV;
          lamp_st.stopped_count = '0;
          lamp_st.stop_shown    = 1'b0;
        end else if (sp > thr) begin
          dir = DIR_FWD;
          lamp_st.stopped_count = '0;
          lamp_st.stop_shown    = 1'b0;
        end else if (lamp_st.stopped_count != COUNT_MAX) begin
          lamp_st.stopped_count = lamp_st.stopped_count + 8'd1;
        end
        // charging has just ended: force a fresh stop
        if (!lamp_st.charging_now && !lamp_st.full_now && lamp_st.prior_flags[1]) begin
          dir = DIR_STOP;
          lamp_st.stopped_count = lamp_cfg.stop_ticks;
          lamp_st.stop_shown    = 1'b0;
        end
        flags = {lamp_st.full_now, lamp_st.charging_now, lamp_st.emergency_clear};
        if (dir != lamp_st.shown_direction || flags != lamp_st.prior_flags ||
            (!lamp_st.stop_shown && lamp_st.stopped_count >= lamp_cfg.stop_ticks)) begin
          emit = 1'b1;
          if (lamp_st.full_now)             lamp = '{PAT_FULL, MODE_FULL};
          else if (lamp_st.charging_now)    lamp = '{PAT_CHARGING, MODE_CHARGING};
          else if (!lamp_st.emergency_clear) lamp = '{PAT_EMERG, MODE_EMERG};
          else if (dir == DIR_REV)          lamp = '{PAT_REVERSE, MODE_REVERSE};
          else if (dir == DIR_FWD)          lamp = '{PAT_FORWARD, MODE_FORWARD};
          else if (lamp_st.stopped_count >= lamp_cfg.stop_ticks && !lamp_st.stop_shown)
          begin
            lamp = '{PAT_STOPPED, MODE_STOPPED};
            lamp_st.stop_shown = 1'b1;
          end else begin
            // change seen but nothing to show
            emit = 1'b0;
          end
          lamp_st.shown_direction = dir;
          lamp_st.prior_flags     = flags;
        end
      end
    endcase
    return emit;
  endfunction

  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(7);
  endfunction

  // Random event: fields unused by the kind stay random, used ones are shaped
  // around the current thresholds and the extremes.
  function automatic in_item_t rand_event(input int unsigned tick_pct,
                                          input int unsigned speed_pct);
    logic [63:0] raw;
    in_item_t    ev;
    int unsigned r;
    int          thr;
    int          sp;
    raw = {$urandom, $urandom};
    ev  = raw[$bits(in_item_t)-1:0];
    r   = $urandom_range(99);
    thr = lamp_cfg.speed_threshold;
    if (r < tick_pct) begin
      ev.operation = OP_TICK;
    end else if (r < tick_pct + speed_pct) begin
      ev.operation = OP_SPEED;
      case ($urandom_range(3))
        0: sp = int'(ev.speed_mm_s);
        1: sp = thr + int'($urandom_range(2)) - 1;
        2: sp = -thr + int'($urandom_range(2)) - 1;
        default: sp = $urandom_range(1) ? 32767 : -32768;
      endcase
      ev.speed_mm_s = sp[15:0];
    end else if (r[0]) begin
      ev.operation = OP_EMERG;
      // favour release so that both levels of the emergency flag recur
      if ($urandom_range(1)) {ev.stop_input_a, ev.stop_input_b} = 2'b11;
    end else begin
      ev.operation = OP_BATT;
      case ($urandom_range(2))
        0: ;
        1: ev.voltage_mv = lamp_cfg.full_voltage_mv + 16'($urandom_range(2)) - 16'd1;
        default: ev.voltage_mv = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
    end
    return ev;
  endfunction

  // Offer one event after a random gap; hold it until it is taken.
  task automatic offer_event(input in_item_t ev, input bit typed, input bit has_lamp,
                             input out_item_t lamp);
    int unsigned gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= ev;
    typed_on   = typed;
    typed_has  = has_lamp;
    typed_lamp = lamp;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SPEED_THRESHOLD: lamp_cfg.speed_threshold     = val[14:0];
      CFG_SPEED_TIMEOUT:   lamp_cfg.speed_timeout_ticks = val[7:0];
      CFG_STOP_TICKS:      lamp_cfg.stop_ticks          = val[7:0];
      default:             lamp_cfg.full_voltage_mv     = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count, input int unsigned tick_pct,
                            input int unsigned speed_pct);
    int unsigned n;
    for (n = 0; n < count; n++) begin
      // switch idling on and off in stretches
      if (n % 40 == 0) calm = ($urandom_range(3) == 0);
      offer_event(rand_event(tick_pct, speed_pct), 1'b0, 1'b0, NO_LAMP);
    end
  endtask

  // Drop valid, let every expected lamp arrive, then allow for the latency.
  task automatic settle();
    int unsigned n;
    @(negedge clk);
    in_valid <= 1'b0;
    for (n = 0; n < 2000 && pending_lamps.size() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Scoreboard: check delivered lamps first, then predict for the event taken.
  always @(posedge clk) begin : score
    out_item_t want;
    out_item_t lamp;
    bit        got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_lamps.size() == 0) begin
          $error("unexpected lamp result: pattern %h, mode %0d",
                 out_data.lamp_pattern, out_data.mode_code);
          fail_count++;
        end else begin
          want = pending_lamps.pop_front();
          if (out_data.lamp_pattern !== want.lamp_pattern) begin
            $error("lamp_pattern: expected %h, got %h", want.lamp_pattern,
                   out_data.lamp_pattern);
            fail_count++;
          end
          if (out_data.mode_code !== want.mode_code) begin
            $error("mode_code: expected %0d, got %0d", want.mode_code,
                   out_data.mode_code);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        got = next_lamp(in_data, lamp);
        // a typed-in row overrides the prediction, the state still advances
        if (typed_on) begin
          got  = typed_has;
          lamp = typed_lamp;
        end
        if (got) pending_lamps = {pending_lamps, lamp};
      end
    end
  end

  // Result side: draw a gap per result, then accept until one is taken.
  initial begin : take_lamps
    int unsigned gap;
    forever begin
      gap = idle_draw();
      @(negedge clk);
      if (gap != 0) begin
        rx_want <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rx_want <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin : long_hold
    int unsigned k;
    wait (hold_req);
    @(negedge clk);
    hold_off <= 1'b1;
    for (k = 0; k < 300; k++) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #3000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int          i;
    int          k;
    logic [63:0] raw;
    in_item_t    ev;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk through every kind and the priority chain at reset values
    for (i = 0; i < PLAN_LEN; i++) begin
      raw = {$urandom, $urandom};
      ev  = raw[$bits(in_item_t)-1:0];
      ev.operation = plan[i].op;
      case (plan[i].op)
        OP_SPEED: ev.speed_mm_s = plan[i].arg;
        OP_EMERG: {ev.stop_input_a, ev.stop_input_b} = {plan[i].line_a, plan[i].line_b};
        OP_BATT: begin
          ev.is_charging = plan[i].charging;
          ev.voltage_mv  = plan[i].arg;
        end
        default: ;
      endcase
      offer_event(ev, plan[i].typed, plan[i].has_lamp, plan[i].lamp);
    end
    settle();

    // Low extremes: zero threshold, zero timeout, zero stop ticks, always full
    write_reg(CFG_SPEED_THRESHOLD, 16'd0);
    write_reg(CFG_SPEED_TIMEOUT, 16'd0);
    write_reg(CFG_STOP_TICKS, 16'd0);
    write_reg(CFG_FULL_VOLTAGE, 16'd0);
    run_random(150, 45, 25);
    settle();

    // High extremes; the top bit of the threshold write falls outside the register
    write_reg(CFG_SPEED_THRESHOLD, 16'hFFFF);
    write_reg(CFG_SPEED_TIMEOUT, 16'd255);
    write_reg(CFG_STOP_TICKS, 16'd255);
    write_reg(CFG_FULL_VOLTAGE, 16'hFFFF);
    run_random(150, 55, 20);
    settle();

    // Long tick run with no speed samples: stopped count and speed age saturate
    write_reg(CFG_SPEED_THRESHOLD, 16'd40);
    write_reg(CFG_STOP_TICKS, 16'd200);
    write_reg(CFG_FULL_VOLTAGE, 16'd29500);
    ev = '0;
    ev.operation  = OP_SPEED;
    ev.speed_mm_s = 16'sd3;
    offer_event(ev, 1'b0, 1'b0, NO_LAMP);
    run_random(300, 90, 0);
    settle();

    // Mid settings, with the receiver held off to back the block up
    write_reg(CFG_SPEED_THRESHOLD, 16'($urandom_range(50, 300)));
    write_reg(CFG_SPEED_TIMEOUT, 16'd3);
    write_reg(CFG_STOP_TICKS, 16'd2);
    write_reg(CFG_FULL_VOLTAGE, 16'd28000);
    run_random(80, 45, 25);
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) begin
      raw = {$urandom, $urandom};
      ev  = raw[$bits(in_item_t)-1:0];
      if (k % 2 == 0) begin
        // alternate direction so every tick changes the pattern
        ev.operation  = OP_SPEED;
        ev.speed_mm_s = (k % 4 == 0) ? 16'sd1000 : -16'sd1000;
      end else begin
        ev.operation = OP_TICK;
      end
      offer_event(ev, 1'b0, 1'b0, NO_LAMP);
    end
    run_random(90, 45, 25);
    settle();

    if (pending_lamps.size() != 0) begin
      $error("%0d expected lamp results never arrived", pending_lamps.size());
      fail_count++;
    end
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/vlmc_pkg.sv
rtl/vlmc_step.sv
rtl/vehicle_lamp_mode_controller_unit.sv
tb/sv/tb.sv
